// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the counter bank.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg
// Types and constants shared by the preset counter bank modules.
// ----------------------------------------------------------------------------
package pcb_pkg;

  localparam int NUM_COUNTERS = 8;
  localparam int RATE_SLOTS   = 10;
  localparam int TIME_COUNTER = 0;

  localparam int CW      = $clog2(NUM_COUNTERS);
  localparam int SW      = $clog2(RATE_SLOTS + 1);
  localparam int CNT_W   = 48;
  localparam int RATE_W  = 32;
  localparam int TIME_W  = 32;
  localparam int MC_W    = 4;
  localparam int DIV_W   = CNT_W + 10;
  localparam int SUM_W   = RATE_W + $clog2(RATE_SLOTS);
  localparam int RING_N  = NUM_COUNTERS * RATE_SLOTS;
  localparam int RA_W    = $clog2(RING_N);
  localparam int IN_W    = 88;
  localparam int OUT_W   = 88;
  localparam int CFG_AW  = 1;

  // t / 1000 == (t * MS_RECIP) >> MS_SHIFT for every 32-bit t
  localparam logic [RATE_W-1:0] MS_RECIP  = 32'h10624DD3;
  localparam int                MS_SHIFT  = 38;
  localparam logic [MC_W-1:0]   MC_RESET  = 4'd8;

  localparam logic [CFG_AW-1:0] REG_MASTER_COUNTER = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MASTER_PRESET  = 1'b1;

  typedef enum logic [2:0] {
    FN_TICK, FN_SET, FN_CLEAR, FN_START, FN_STOP, FN_RATE, FN_MEAN, FN_NOP
  } func_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_TICK_TIME, OP_DIV_T, OP_SET_WR, OP_SET_CHK, OP_CLR,
    OP_START, OP_STOP, OP_RATE_SKIP, OP_RATE_FILL, OP_RATE_DIFF, OP_RATE_MUL,
    OP_RATE_DIV, OP_RATE_WR, OP_RATE_END, OP_MEAN_CLR, OP_MEAN_RD, OP_MEAN_ACC,
    OP_MEAN_DIV, OP_MEAN_WR, OP_LOAD
  } op_t;

  typedef enum logic [1:0] {SEL_IDX, SEL_TIME, SEL_LOOP} sel_t;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    logic            use_q;
    logic [CW-1:0]   loop;
    logic [SW-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    func_t           func;
    logic            idx_ok;
    logic            run_flag;
    logic            run_time_zero;
    logic            last_ge_run;
    logic            armed;
    logic            fill_gt1;
    logic [SW-1:0]   fill;
    logic            div_done;
  } sts_t;

endpackage

// File: sv/pcb_div.sv
// ----------------------------------------------------------------------------
// pcb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcb_div
  import pcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic [DIV_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic [RATE_W-1:0]   rem;
  logic [DIV_W-1:0]    quo;
  logic [RATE_W-1:0]   dvs;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [RATE_W:0]     trial;
  logic [RATE_W:0]     diff;
  logic                take;

  assign trial    = {rem, quo[DIV_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign take     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo <= {quo[DIV_W-2:0], take};
    end
  end

  `include "assert_macros.svh"

  `ASSERT_RST(a_done_pulse, done |=> !done, "divider done held longer than one cycle")
  `ASSERT_RST(a_start_busy, start |=> busy && !done, "divider not busy after start")

endmodule

// File: sv/pcb_dp.sv
// ----------------------------------------------------------------------------
// pcb_dp
// Counter bank datapath: counter state, rate ring, divider and result register.
// ----------------------------------------------------------------------------
module pcb_dp
  import pcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [IN_W-1:0]   in_tdata,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  localparam logic [CW-1:0] TIME_IDX = CW'(TIME_COUNTER);
  localparam logic          TIME_OK  = TIME_COUNTER < NUM_COUNTERS;

  function automatic logic is_master(input logic [MC_W-1:0] mc, input logic [CW-1:0] c);
    return (32'(mc) < NUM_COUNTERS) && (mc == MC_W'(c));
  endfunction

  logic [CNT_W-1:0]  cnt_now  [NUM_COUNTERS];
  logic [CNT_W-1:0]  cnt_prev [NUM_COUNTERS];
  logic [CNT_W-1:0]  cnt_off  [NUM_COUNTERS];
  logic [CNT_W-1:0]  cnt_base [NUM_COUNTERS];
  logic [RATE_W-1:0] avg      [NUM_COUNTERS];
  logic [SW-1:0]     fill     [NUM_COUNTERS];
  logic [SW-1:0]     slot     [NUM_COUNTERS];
  logic [RATE_SLOTS-1:0]   ring_valid [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] stopped_flags;
  logic              run_flag;
  logic              stop_pending;
  logic              armed;
  logic              req;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] run_time;
  logic [TIME_W-1:0] last_rate_time;
  logic [MC_W-1:0]   master_counter;
  logic [CNT_W-1:0]  master_preset;

  func_t             func_r;
  logic [2:0]        idx_r;
  logic [CNT_W-1:0]  val_r;
  logic [TIME_W-1:0] t_r;
  logic [CNT_W-1:0]  diff;
  logic [DIV_W-1:0]  prod;
  logic [SUM_W-1:0]  sum;
  logic [63:0]       t_prod;
  logic [CNT_W-1:0]  secs;

  logic [RATE_W-1:0] ring_mem [RING_N];
  logic [RATE_W-1:0] ring_q;
  logic              ring_vq;
  logic [RATE_W-1:0] ring_data;

  logic [CW-1:0]     a;
  logic [CNT_W-1:0]  now_a;
  logic [SW-1:0]     fill_a;
  logic [SW-1:0]     slot_a;
  logic [CNT_W-1:0]  set_v;
  logic [CNT_W-1:0]  set_sum;
  logic [CNT_W-1:0]  clr_base;
  logic [RATE_W-1:0] rate_val;
  logic [RA_W-1:0]   wr_addr;
  logic [RA_W-1:0]   rd_addr;
  logic              idx_ok;
  logic              limit;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [RATE_W-1:0] div_divisor;
  logic [DIV_W-1:0]  quotient;
  logic              div_done;

  always_comb begin
    case (cmd.sel)
      SEL_IDX:  a = CW'(idx_r);
      SEL_TIME: a = TIME_IDX;
      default:  a = cmd.loop;
    endcase
  end

  assign now_a    = cnt_now[a];
  assign fill_a   = fill[a];
  assign slot_a   = slot[a];
  assign idx_ok   = 32'(idx_r) < NUM_COUNTERS;
  assign t_prod   = 64'(t_r) * 64'(MS_RECIP);
  assign set_v    = cmd.use_q ? secs : val_r;
  assign set_sum  = cnt_off[a] + set_v - cnt_base[a];
  assign clr_base = cnt_base[a] + now_a - cnt_off[a];
  assign wr_addr  = RA_W'(32'(a) * RATE_SLOTS) + RA_W'(slot_a);
  assign rd_addr  = RA_W'(32'(a) * RATE_SLOTS) + RA_W'(cmd.slot);
  assign ring_data = ring_vq ? ring_q : '0;
  assign limit    = is_master(master_counter, a) && (now_a >= master_preset);

  always_comb begin
    if (fill_a > SW'(1)) begin
      rate_val = (|quotient[DIV_W-1:RATE_W]) ? '1 : quotient[RATE_W-1:0];
    end else begin
      rate_val = '0;
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = run_time - last_rate_time;
    case (cmd.op)
      OP_RATE_DIV: begin
        div_start = 1'b1;
      end
      OP_MEAN_DIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum);
        div_divisor  = RATE_W'(fill_a - 1'b1);
      end
      default: ;
    endcase
  end

  pcb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    sts.func          = func_r;
    sts.idx_ok        = idx_ok;
    sts.run_flag      = run_flag;
    sts.run_time_zero = run_time == '0;
    sts.last_ge_run   = last_rate_time >= run_time;
    sts.armed         = armed;
    sts.fill_gt1      = fill_a > SW'(1);
    sts.fill          = fill_a;
    sts.div_done      = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RATE_WR) begin
      ring_mem[wr_addr] <= rate_val;
    end
    if (cmd.op == OP_MEAN_RD) begin
      ring_q  <= ring_mem[rd_addr];
      ring_vq <= ring_valid[a][cmd.slot];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        func_r <= func_t'(in_tdata[2:0]);
        idx_r  <= in_tdata[5:3];
        val_r  <= in_tdata[53:6];
        t_r    <= in_tdata[85:54];
      end
      OP_DIV_T: secs <= CNT_W'(t_prod[63:MS_SHIFT]);
      OP_RATE_DIFF: diff <= now_a - cnt_prev[a];
      OP_RATE_MUL: begin
        prod <= (DIV_W'(diff) << 10) - (DIV_W'(diff) << 4) - (DIV_W'(diff) << 3);
      end
      OP_MEAN_CLR: sum <= '0;
      OP_MEAN_ACC: sum <= sum + SUM_W'(ring_data);
      OP_LOAD: begin
        if (idx_ok) begin
          out_tdata <= {4'b0, run_flag, req, limit, stopped_flags[a], avg[a], now_a};
        end else begin
          out_tdata <= {4'b0, run_flag, req, 82'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_COUNTERS; c++) begin
        cnt_now[c]    <= '0;
        cnt_prev[c]   <= '0;
        cnt_off[c]    <= '0;
        cnt_base[c]   <= '0;
        avg[c]        <= '0;
        fill[c]       <= '0;
        slot[c]       <= '0;
        ring_valid[c] <= '0;
      end
      stopped_flags  <= '0;
      run_flag       <= 1'b0;
      stop_pending   <= 1'b0;
      armed          <= 1'b0;
      req            <= 1'b0;
      start_time     <= '0;
      run_time       <= '0;
      last_rate_time <= '0;
      master_counter <= MC_RESET;
      master_preset  <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_MASTER_COUNTER) begin
          master_counter <= cfg_wdata[MC_W-1:0];
        end else if (cfg_addr == REG_MASTER_PRESET) begin
          master_preset <= cfg_wdata;
        end
      end
      case (cmd.op)
        OP_LATCH:     req <= 1'b0;
        OP_TICK_TIME: run_time <= t_r - start_time;
        OP_SET_WR: begin
          cnt_now[a] <= set_sum;
          if (set_v == '0) begin
            ring_valid[a] <= '0;
            avg[a]        <= '0;
            cnt_off[a]    <= '0;
            cnt_base[a]   <= '0;
          end
        end
        OP_SET_CHK: begin
          if (is_master(master_counter, a) && master_preset != '0 &&
              now_a >= master_preset && !stop_pending) begin
            stopped_flags[a] <= 1'b1;
            stop_pending     <= 1'b1;
            req              <= 1'b1;
          end
        end
        OP_CLR: begin
          if (TIME_OK && a == TIME_IDX && run_flag) begin
            cnt_base[a] <= clr_base;
          end
          cnt_now[a]    <= '0;
          ring_valid[a] <= '0;
          avg[a]        <= '0;
          cnt_off[a]    <= '0;
          fill[a]       <= '0;
          slot[a]       <= '0;
        end
        OP_START: begin
          run_flag      <= 1'b1;
          stop_pending  <= 1'b0;
          start_time    <= t_r;
          armed         <= 1'b0;
          stopped_flags <= '0;
          for (int c = 0; c < NUM_COUNTERS; c++) begin
            avg[c]  <= '0;
            fill[c] <= '0;
            slot[c] <= '0;
          end
          if (TIME_OK) begin
            cnt_now[TIME_IDX]  <= cnt_off[TIME_IDX];
            cnt_base[TIME_IDX] <= secs;
          end
        end
        OP_STOP: begin
          run_flag     <= 1'b0;
          stop_pending <= 1'b0;
          if (TIME_OK) begin
            cnt_off[TIME_IDX] <= cnt_now[TIME_IDX];
          end
        end
        OP_RATE_SKIP: last_rate_time <= run_time;
        OP_RATE_FILL: begin
          if (fill_a < SW'(RATE_SLOTS)) begin
            fill[a] <= fill_a + 1'b1;
          end
        end
        OP_RATE_WR: begin
          ring_valid[a][slot_a] <= 1'b1;
          cnt_prev[a]           <= now_a;
          slot[a] <= (slot_a == SW'(RATE_SLOTS - 1)) ? '0 : slot_a + 1'b1;
        end
        OP_RATE_END: begin
          last_rate_time <= run_time;
          armed          <= 1'b1;
        end
        OP_MEAN_WR: avg[a] <= (fill_a > SW'(1)) ? quotient[RATE_W-1:0] : '0;
        default: ;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_RST(a_req_pending, req |-> stop_pending, "stop request without pending stop")
  `ASSERT_ANY(a_reset_idle, rst |=> !run_flag && !req, "run or request survived reset")

endmodule

// File: sv/pcb_ctrl.sv
// ----------------------------------------------------------------------------
// pcb_ctrl
// Sequencer for the counter bank: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module pcb_ctrl
  import pcb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_TICK, S_DIVT, S_SET_WR, S_SET_CHK, S_CLR,
    S_START, S_STOP, S_RATE_SKIP, S_RATE_FILL, S_RATE_TEST, S_RATE_DIFF,
    S_RATE_MUL, S_RATE_DIV, S_RATE_WAIT, S_RATE_WR, S_RATE_END, S_MEAN_CLR,
    S_MEAN_TEST, S_MEAN_RD, S_MEAN_ACC, S_MEAN_DIV, S_MEAN_WAIT, S_MEAN_WR, S_DONE
  } state_t;

  localparam logic [CW-1:0] LAST = CW'(NUM_COUNTERS - 1);
  localparam logic          TIME_OK = TIME_COUNTER < NUM_COUNTERS;

  state_t        st;
  logic [CW-1:0] loop;
  logic [SW-1:0] slot_d;
  logic          tick;
  logic          load;

  assign in_tready = st == S_IDLE;
  assign tick      = sts.func == FN_TICK;
  assign load      = st == S_DONE && (!out_tvalid || out_tready);

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.sel   = SEL_LOOP;
    cmd.use_q = tick;
    cmd.loop  = loop;
    cmd.slot  = slot_d;
    case (st)
      S_IDLE:      if (in_tvalid) cmd.op = OP_LATCH;
      S_TICK:      cmd.op = OP_TICK_TIME;
      S_DIVT:      cmd.op = OP_DIV_T;
      S_SET_WR: begin
        cmd.op  = OP_SET_WR;
        cmd.sel = tick ? SEL_TIME : SEL_IDX;
      end
      S_SET_CHK: begin
        cmd.op  = OP_SET_CHK;
        cmd.sel = tick ? SEL_TIME : SEL_IDX;
      end
      S_CLR: begin
        cmd.op  = OP_CLR;
        cmd.sel = SEL_IDX;
      end
      S_START:     cmd.op = OP_START;
      S_STOP:      cmd.op = OP_STOP;
      S_RATE_SKIP: cmd.op = OP_RATE_SKIP;
      S_RATE_FILL: cmd.op = OP_RATE_FILL;
      S_RATE_DIFF: cmd.op = OP_RATE_DIFF;
      S_RATE_MUL:  cmd.op = OP_RATE_MUL;
      S_RATE_DIV:  cmd.op = OP_RATE_DIV;
      S_RATE_WR:   cmd.op = OP_RATE_WR;
      S_RATE_END:  cmd.op = OP_RATE_END;
      S_MEAN_CLR:  cmd.op = OP_MEAN_CLR;
      S_MEAN_RD:   cmd.op = OP_MEAN_RD;
      S_MEAN_ACC:  cmd.op = OP_MEAN_ACC;
      S_MEAN_DIV:  cmd.op = OP_MEAN_DIV;
      S_MEAN_WR:   cmd.op = OP_MEAN_WR;
      S_DONE: begin
        cmd.sel = SEL_IDX;
        if (load) cmd.op = OP_LOAD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      loop       <= '0;
      slot_d     <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (load) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      case (st)
        S_IDLE: if (in_tvalid) st <= S_DECODE;
        S_DECODE: begin
          loop <= '0;
          case (sts.func)
            FN_TICK:  st <= sts.run_flag ? S_TICK : S_DONE;
            FN_SET:   st <= sts.idx_ok ? S_SET_WR : S_DONE;
            FN_CLEAR: st <= sts.idx_ok ? S_CLR : S_DONE;
            FN_START: st <= S_DIVT;
            FN_STOP:  st <= S_STOP;
            FN_RATE: begin
              if (sts.run_time_zero) st <= S_DONE;
              else if (sts.last_ge_run) st <= S_RATE_SKIP;
              else if (sts.armed) st <= S_RATE_FILL;
              else st <= S_RATE_END;
            end
            FN_MEAN:  st <= S_MEAN_CLR;
            default:  st <= S_DONE;
          endcase
        end
        S_TICK:      st <= TIME_OK ? S_DIVT : S_DONE;
        S_DIVT:      st <= tick ? S_SET_WR : S_START;
        S_SET_WR:    st <= S_SET_CHK;
        S_SET_CHK:   st <= S_DONE;
        S_CLR:       st <= S_DONE;
        S_START:     st <= S_DONE;
        S_STOP:      st <= S_DONE;
        S_RATE_SKIP: st <= S_DONE;
        S_RATE_FILL: st <= S_RATE_TEST;
        S_RATE_TEST: st <= sts.fill_gt1 ? S_RATE_DIFF : S_RATE_WR;
        S_RATE_DIFF: st <= S_RATE_MUL;
        S_RATE_MUL:  st <= S_RATE_DIV;
        S_RATE_DIV:  st <= S_RATE_WAIT;
        S_RATE_WAIT: if (sts.div_done) st <= S_RATE_WR;
        S_RATE_WR: begin
          if (loop == LAST) begin
            st <= S_RATE_END;
          end else begin
            loop <= loop + 1'b1;
            st   <= S_RATE_FILL;
          end
        end
        S_RATE_END:  st <= S_DONE;
        S_MEAN_CLR: begin
          slot_d <= SW'(1);
          st     <= S_MEAN_TEST;
        end
        S_MEAN_TEST: begin
          if (slot_d < sts.fill) st <= S_MEAN_RD;
          else if (sts.fill_gt1) st <= S_MEAN_DIV;
          else st <= S_MEAN_WR;
        end
        S_MEAN_RD:   st <= S_MEAN_ACC;
        S_MEAN_ACC: begin
          slot_d <= slot_d + 1'b1;
          st     <= S_MEAN_TEST;
        end
        S_MEAN_DIV:  st <= S_MEAN_WAIT;
        S_MEAN_WAIT: if (sts.div_done) st <= S_MEAN_WR;
        S_MEAN_WR: begin
          if (loop == LAST) begin
            st <= S_DONE;
          end else begin
            loop <= loop + 1'b1;
            st   <= S_MEAN_CLR;
          end
        end
        S_DONE: begin
          if (load) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_RST(a_load_valid, load |=> out_tvalid && st == S_IDLE, "result not presented")
  `ASSERT_RST(a_accept_decode, in_tvalid && in_tready |=> st == S_DECODE, "item not decoded")
  `ASSERT_ANY(a_reset_state, rst |=> st == S_IDLE && !out_tvalid, "reset left sequencer busy")

endmodule

// File: sv/preset_counter_bank_with_rates.sv
// ----------------------------------------------------------------------------
// preset_counter_bank_with_rates
// Eight acquisition counters with master preset stop and rate averaging.
// ----------------------------------------------------------------------------
// Usage: one command item enters on s_axis_*, one result item leaves on
// m_axis_*. cfg_we/cfg_addr/cfg_wdata write master_counter (0) and
// master_preset (1); write only while the block is idle.
// A rate or mean update runs up to one division per counter.
// The shared 58-step serial divider serves both rate and mean updates;
// seconds for the time counter come from a reciprocal multiply. One item is
// worked on at a time. A result waits in the output register while the next
// item is accepted; if out_tready stays low, the block holds before loading
// the next result. Reset (rst, synchronous) clears all counters, rings,
// flags and times, sets master_counter to none and drops out_tvalid.
// ----------------------------------------------------------------------------
module preset_counter_bank_with_rates
  import pcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // func[2:0], counter_index[5:3], count_value[53:6], time_ms[85:54]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // counter_value[47:0], mean_rate[79:48], stopped[80], limit_reached[81],
  // stop_request[82], run_active[83]
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  pcb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pcb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (s_axis_tdata),
    .out_tdata (m_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// File: dv/preset_counter_bank_with_rates_test.sv
// ----------------------------------------------------------------------------
// preset_counter_bank_with_rates_test
// Drives command items into the counter bank, predicts every result item
// from an internal copy of the counter, ring and run state, and compares
// each result field by field. Covers directed corner cases, random runs
// under several master settings, random idling and a long output stall.
// ----------------------------------------------------------------------------
module preset_counter_bank_with_rates_test;
  import pcb_pkg::*;

  localparam int NC = NUM_COUNTERS;
  localparam int NS = RATE_SLOTS;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic run;
    logic req;
    logic limit;
    logic stopped;
    logic [31:0] mean;
    logic [47:0] value;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  preset_counter_bank_with_rates dut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [3:0] mast;
  logic [47:0] preset;
  logic [47:0] cnow[NC], cprev[NC], coff[NC], cbase[NC];
  logic [31:0] ring[NC][NS];
  logic [31:0] avg[NC];
  int fill[NC], slot[NC];
  logic [NC-1:0] stopf;
  logic running, pend, armed;
  logic [31:0] t_start, t_run, t_lastrate;

  result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit gaps_on = 1;
  logic [31:0] now_ms;

  function automatic bit is_mast(int c);
    return mast < NC && mast == c;
  endfunction

  function automatic void wipe_rates(int c);
    for (int s = 0; s < NS; s++) ring[c][s] = 0;
    avg[c] = 0;
  endfunction

  function automatic bit load_count(int c, logic [47:0] v);
    cnow[c] = (coff[c] + v - cbase[c]) & M48;
    if (v == 0) begin
      wipe_rates(c);
      coff[c] = 0;
      cbase[c] = 0;
    end
    if (is_mast(c) && preset != 0 && cnow[c] >= preset && !pend) begin
      stopf[c] = 1;
      pend = 1;
      return 1;
    end
    return 0;
  endfunction

  function automatic void predict_bank(func_t f, int idx, logic [47:0] v, logic [31:0] t);
    result_t r;
    bit req;
    logic [63:0] d, q, sum;
    int n;
    req = 0;
    case (f)
      FN_TICK: if (running) begin
        t_run = t - t_start;
        req = load_count(TIME_COUNTER, 48'(t / 1000));
      end
      FN_SET: req = load_count(idx, v);
      FN_CLEAR: begin
        if (idx == TIME_COUNTER && running)
          cbase[idx] = (cbase[idx] + cnow[idx] - coff[idx]) & M48;
        cnow[idx] = 0;
        wipe_rates(idx);
        coff[idx] = 0;
        fill[idx] = 0;
        slot[idx] = 0;
      end
      FN_START: begin
        running = 1; pend = 0; t_start = t; armed = 0; stopf = 0;
        for (int c = 0; c < NC; c++) begin
          avg[c] = 0; fill[c] = 0; slot[c] = 0;
          if (c == TIME_COUNTER) begin
            cnow[c] = coff[c];
            cbase[c] = 48'(t / 1000);
          end
        end
      end
      FN_STOP: begin
        running = 0; pend = 0;
        coff[TIME_COUNTER] = cnow[TIME_COUNTER];
      end
      FN_RATE: if (t_run != 0) begin
        if (t_lastrate >= t_run) t_lastrate = t_run;
        else begin
          if (armed) for (int c = 0; c < NC; c++) begin
            logic [31:0] rr;
            rr = 0;
            if (fill[c] < NS) fill[c]++;
            if (fill[c] > 1) begin
              d = 64'((cnow[c] - cprev[c]) & M48);
              q = d * 1000 / 64'(t_run - t_lastrate);
              rr = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            ring[c][slot[c]] = rr;
            cprev[c] = cnow[c];
            slot[c] = (slot[c] + 1 >= NS) ? 0 : slot[c] + 1;
          end
          t_lastrate = t_run;
          armed = 1;
        end
      end
      FN_MEAN: for (int c = 0; c < NC; c++) begin
        sum = 0;
        n = fill[c] > NS ? NS : fill[c];
        for (int s = 1; s < n; s++) sum += ring[c][s];
        avg[c] = n > 1 ? 32'(sum / 64'(n - 1)) : 0;
      end
      default: ;
    endcase
    r.value = cnow[idx];
    r.mean = avg[idx];
    r.stopped = stopf[idx];
    r.limit = is_mast(idx) && cnow[idx] >= preset;
    r.req = req;
    r.run = running;
    expected_q.push_back(r);
  endfunction

  task automatic send_item(func_t f, int idx, logic [47:0] v, logic [31:0] t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tdata <= {2'b0, t, v, 3'(idx), 3'(f)};
    s_axis_tvalid <= 1;
    predict_bank(f, idx, v, t);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] a, logic [47:0] v);
    cfg_we <= 1; cfg_addr <= a; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    if (a == REG_MASTER_COUNTER) mast = v[3:0]; else preset = v;
    @(posedge clk);
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) m_axis_tready <= 0;
      else m_axis_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 15) == 0);
    end
  end

  always @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("preset_counter_bank_with_rates_test failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_t e, a;
      a = m_axis_tdata[83:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected item %h", $time, a);
      end else begin
        e = expected_q.pop_front();
        if (a.value !== e.value) begin errors++;
          $display("%0t counter_value exp %h act %h", $time, e.value, a.value); end
        if (a.mean !== e.mean) begin errors++;
          $display("%0t mean_rate exp %h act %h", $time, e.mean, a.mean); end
        if (a.stopped !== e.stopped) begin errors++;
          $display("%0t stopped exp %b act %b", $time, e.stopped, a.stopped); end
        if (a.limit !== e.limit) begin errors++;
          $display("%0t limit_reached exp %b act %b", $time, e.limit, a.limit); end
        if (a.req !== e.req) begin errors++;
          $display("%0t stop_request exp %b act %b", $time, e.req, a.req); end
        if (a.run !== e.run) begin errors++;
          $display("%0t run_active exp %b act %b", $time, e.run, a.run); end
      end
    end
  end

  task automatic test_directed();
    send_item(FN_RATE, 0, 0, 0);
    send_item(FN_NOP, 7, M48, 32'hFFFF_FFFF);
    send_item(FN_SET, 3, M48, 0);
    send_item(FN_TICK, 0, 0, 5000);
    send_item(FN_START, 0, 0, 32'hFFFF_FFFF);
    send_item(FN_TICK, 2, 0, 32'hFFFF_FFFF);
    send_item(FN_START, 1, 0, 1000);
    send_item(FN_RATE, 1, 0, 0);
    send_item(FN_TICK, 0, 0, 2000);
    send_item(FN_RATE, 0, 0, 0);
    send_item(FN_RATE, 0, 0, 0);
    send_item(FN_SET, 1, 48'd1000, 0);
    send_item(FN_TICK, 0, 0, 2001);
    send_item(FN_RATE, 1, 0, 0);
    send_item(FN_SET, 1, 48'd5, 0);
    send_item(FN_SET, 2, M48, 0);
    send_item(FN_TICK, 0, 0, 2002);
    send_item(FN_RATE, 2, 0, 0);
    send_item(FN_MEAN, 2, 0, 0);
    send_item(FN_MEAN, 1, 0, 0);
    send_item(FN_SET, 2, 0, 0);
    send_item(FN_CLEAR, 0, 0, 0);
    send_item(FN_STOP, 0, 0, 0);
    send_item(FN_CLEAR, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_preset();
    write_reg(REG_MASTER_COUNTER, 48'd4);
    write_reg(REG_MASTER_PRESET, 48'd100);
    send_item(FN_START, 4, 0, 0);
    send_item(FN_SET, 4, 48'd99, 0);
    send_item(FN_SET, 4, 48'd100, 0);
    send_item(FN_SET, 4, 48'd200, 0);
    send_item(FN_STOP, 4, 0, 0);
    send_item(FN_SET, 4, 48'd300, 0);
    wait_drained();
    write_reg(REG_MASTER_PRESET, 48'd0);
    send_item(FN_SET, 4, 48'd0, 0);
    send_item(FN_SET, 4, 48'd7, 0);
    wait_drained();
  endtask

  // a run of random activity, mostly well-formed
  task automatic random_run(int items);
    logic [31:0] t;
    int k;
    t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100000);
    send_item(FN_START, $urandom_range(0, 7), 0, t);
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      t = t + $urandom_range(0, 3000);
      if (k < 25) send_item(FN_TICK, $urandom_range(0, 7), 0, t);
      else if (k < 50) send_item(FN_SET, $urandom_range(0, 7),
        $urandom_range(0, 7) == 0 ? 48'({$urandom, $urandom}) :
        ($urandom_range(0, 9) == 0 ? 48'd0 : 48'($urandom_range(0, 200000))), 0);
      else if (k < 62) send_item(FN_RATE, $urandom_range(0, 7), 0, 0);
      else if (k < 70) send_item(FN_MEAN, $urandom_range(0, 7), 0, 0);
      else if (k < 74) send_item(FN_CLEAR, $urandom_range(0, 7), 0, 0);
      else if (k < 76) send_item(FN_STOP, $urandom_range(0, 7), 0, 0);
      else if (k < 78) send_item(FN_START, $urandom_range(0, 7), 0, t);
      else if (k < 80) send_item(FN_NOP, $urandom_range(0, 7), 48'({$urandom, $urandom}),
        $urandom);
      else send_item(func_t'($urandom_range(0, 7)), $urandom_range(0, 7),
        48'({$urandom, $urandom}), $urandom);
    end
    wait_drained();
  endtask

  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_MASTER_COUNTER, p == 0 ? 48'd15 : 48'($urandom_range(0, 8)));
      write_reg(REG_MASTER_PRESET, p == 1 ? M48 : (p == 2 ? 48'd1 :
        48'($urandom_range(0, 400000))));
      gaps_on = (p % 3 != 0);
      random_run(110);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      begin
        gaps_on = 0;
        for (int i = 0; i < 12; i++) send_item(FN_SET, i % 8, 48'(i), 0);
      end
    join
    gaps_on = 1;
    wait_drained();
  endtask

  initial begin
    mast = MC_RESET; preset = 0; stopf = 0;
    running = 0; pend = 0; armed = 0;
    t_start = 0; t_run = 0; t_lastrate = 0;
    for (int c = 0; c < NC; c++) begin
      cnow[c] = 0; cprev[c] = 0; coff[c] = 0; cbase[c] = 0;
      wipe_rates(c); fill[c] = 0; slot[c] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_preset();
    test_backpressure();
    test_random();
    if (errors == 0 && expected_q.size() == 0)
      $display("preset_counter_bank_with_rates_test passed");
    else
      $display("preset_counter_bank_with_rates_test failed");
    $finish;
  end
endmodule
